[rtl/rrli_pkg.sv]
// shared types and constants of the round-robin list interleaver
`default_nettype none

package rrli_pkg;

    localparam int NUM_LISTS_DEF   = 8;
    localparam int LIST_DEPTH_DEF  = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int IDX_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_TAKE   = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_TAKEN    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_APPENDED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_DROPPED  = 2'd3;

    typedef struct packed {
        logic                     func;
        logic [IDX_W-1:0]         list_index;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        logic [IDX_W-1:0]         served_list;
        logic [STATUS_W-1:0]      status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CTRL = 4'b0010,
        S_DATA = 4'b0100,
        S_SEND = 4'b1000
    } t_state;

endpackage

`default_nettype wire

[rtl/rrli_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module rrli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/rrli_pick.sv]
// rotate-priority pick of the first non-empty list at or after the start pointer
`default_nettype none

module rrli_pick #(
    parameter int NUM_LISTS = rrli_pkg::NUM_LISTS_DEF
) (
    input  wire logic [NUM_LISTS-1:0]         i_nonempty,
    input  wire logic [$clog2(NUM_LISTS)-1:0] i_start,
    output logic                              o_found,
    output logic      [$clog2(NUM_LISTS)-1:0] o_list
);

    localparam int LW = $clog2(NUM_LISTS);

    logic [NUM_LISTS-1:0] w_hi;
    logic [LW-1:0]        w_hi_idx;
    logic [LW-1:0]        w_lo_idx;

    always_comb begin
        for (int i = 0; i < NUM_LISTS; i++) begin
            w_hi[i] = i_nonempty[i] && (LW'(i) >= i_start);
        end
    end

    always_comb begin
        w_hi_idx = '0;
        w_lo_idx = '0;
        for (int i = NUM_LISTS - 1; i >= 0; i--) begin
            if (w_hi[i]) begin
                w_hi_idx = LW'(i);
            end
            if (i_nonempty[i]) begin
                w_lo_idx = LW'(i);
            end
        end
    end

    assign o_found = |i_nonempty;
    assign o_list  = (|w_hi) ? w_hi_idx : w_lo_idx;

endmodule

`default_nettype wire

[rtl/round_robin_list_interleaver.sv]
// top level: fifo lists in ram, handed out in round-robin order
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_in_item  (rrli_pkg::t_in_item)
//  out       output     o_out_valid / i_out_stall o_out_item (rrli_pkg::t_out_item)
//
// one transaction at a time: an append passes through the list-control ram read and the
// result register, a take through the list-control ram read, the element ram read and the
// result register; the result then moves to the output register once that is free
// o_in_stall is high while a transaction is in flight or its result waits
// for the output register to free up
// synchronous reset clears the round-robin pointer, non-empty flags and
// per-list control valid bits; the element ram needs no clearing
`default_nettype none

module round_robin_list_interleaver #(
    parameter int NUM_LISTS   = rrli_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH  = rrli_pkg::LIST_DEPTH_DEF,
    parameter int VALUE_WIDTH = rrli_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire rrli_pkg::t_in_item i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output rrli_pkg::t_out_item     o_out_item
);

    localparam int LW = $clog2(NUM_LISTS);
    localparam int HW = $clog2(LIST_DEPTH);
    localparam int FW = $clog2(LIST_DEPTH + 1);
    localparam int CW = HW + FW;
    localparam int ED = NUM_LISTS * LIST_DEPTH;
    localparam int AW = $clog2(ED);

    rrli_pkg::t_state    r_state, n_state;
    logic [LW-1:0]       r_rr, n_rr;
    logic [NUM_LISTS-1:0] r_nonempty, n_nonempty;
    logic [NUM_LISTS-1:0] r_ctrl_vld, n_ctrl_vld;
    logic                r_out_valid, n_out_valid;

    logic                r_func, n_func;
    logic                r_idx_ok, n_idx_ok;
    logic                r_found, n_found;
    logic                r_vldq, n_vldq;
    logic [LW-1:0]       r_list, n_list;
    logic [rrli_pkg::IDX_W-1:0] r_idx_in, n_idx_in;
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    rrli_pkg::t_out_item r_res, n_res;
    rrli_pkg::t_out_item r_out_item, n_out_item;

    logic                w_in_accept;
    logic                w_pick_found;
    logic [LW-1:0]       w_pick_list;
    logic                w_idx_ok;
    logic [LW-1:0]       w_sel_list;

    logic                w_ctrl_rd_en;
    logic                w_ctrl_wr_en;
    logic [CW-1:0]       w_ctrl_wr_data;
    logic [CW-1:0]       w_ctrl_rd_data;
    logic                w_elem_wr_en;
    logic                w_elem_rd_en;
    logic [AW-1:0]       w_elem_addr;
    logic [VALUE_WIDTH-1:0] w_elem_rd_data;
    logic signed [VALUE_WIDTH-1:0] w_elem_s;

    logic [HW-1:0]       w_head;
    logic [FW-1:0]       w_fill;
    logic [HW:0]         w_sum;
    logic [HW-1:0]       w_slot;
    logic [HW-1:0]       w_head_next;
    logic                w_full;

    rrli_pick #(
        .NUM_LISTS (NUM_LISTS)
    ) u_pick (
        .i_nonempty (r_nonempty),
        .i_start    (r_rr),
        .o_found    (w_pick_found),
        .o_list     (w_pick_list)
    );

    rrli_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_LISTS)
    ) u_ctrl_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ctrl_wr_en),
        .i_wr_addr (r_list),
        .i_wr_data (w_ctrl_wr_data),
        .i_rd_en   (w_ctrl_rd_en),
        .i_rd_addr (w_sel_list),
        .o_rd_data (w_ctrl_rd_data)
    );

    rrli_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (ED)
    ) u_elem_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_elem_wr_en),
        .i_wr_addr (w_elem_addr),
        .i_wr_data (r_value),
        .i_rd_en   (w_elem_rd_en),
        .i_rd_addr (w_elem_addr),
        .o_rd_data (w_elem_rd_data)
    );

    assign o_in_stall  = (r_state != rrli_pkg::S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_idx_ok   = (32'(i_in_item.list_index) < NUM_LISTS);
    assign w_sel_list = (i_in_item.func == rrli_pkg::FUNC_TAKE) ? w_pick_list
                      : (w_idx_ok ? LW'(i_in_item.list_index) : '0);

    // list control as read from ram; an entry never written reads as empty
    assign w_head = r_vldq ? w_ctrl_rd_data[HW-1:0]  : '0;
    assign w_fill = r_vldq ? w_ctrl_rd_data[CW-1:HW] : '0;

    assign w_full      = !r_idx_ok || (w_fill == FW'(LIST_DEPTH));
    assign w_sum       = {1'b0, w_head} + (HW+1)'(w_fill);
    assign w_slot      = (w_sum >= (HW+1)'(LIST_DEPTH)) ? HW'(w_sum - (HW+1)'(LIST_DEPTH))
                                                        : HW'(w_sum);
    assign w_head_next = (w_head == HW'(LIST_DEPTH - 1)) ? '0 : w_head + HW'(1);
    assign w_elem_s    = w_elem_rd_data;

    always_comb begin
        n_state     = r_state;
        n_rr        = r_rr;
        n_nonempty  = r_nonempty;
        n_ctrl_vld  = r_ctrl_vld;
        n_func      = r_func;
        n_idx_ok    = r_idx_ok;
        n_found     = r_found;
        n_vldq      = r_vldq;
        n_list      = r_list;
        n_idx_in    = r_idx_in;
        n_value     = r_value;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;

        w_ctrl_rd_en   = 1'b0;
        w_ctrl_wr_en   = 1'b0;
        w_ctrl_wr_data = '0;
        w_elem_wr_en   = 1'b0;
        w_elem_rd_en   = 1'b0;
        w_elem_addr    = AW'(r_list) * AW'(LIST_DEPTH) + AW'(w_head);

        unique case (r_state)
            rrli_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    w_ctrl_rd_en = 1'b1;
                    n_func       = i_in_item.func;
                    n_idx_in     = i_in_item.list_index;
                    n_idx_ok     = w_idx_ok;
                    n_value      = VALUE_WIDTH'($unsigned(i_in_item.value));
                    n_list       = w_sel_list;
                    n_vldq       = r_ctrl_vld[w_sel_list];
                    n_found      = (i_in_item.func == rrli_pkg::FUNC_TAKE) ? w_pick_found
                                                                           : 1'b1;
                    n_state      = rrli_pkg::S_CTRL;
                end
            end
            rrli_pkg::S_CTRL: begin
                n_res.out_value = '0;
                if (r_func == rrli_pkg::FUNC_APPEND) begin
                    n_res.served_list = r_idx_in;
                    n_state           = rrli_pkg::S_SEND;
                    if (w_full) begin
                        n_res.status = rrli_pkg::STAT_DROPPED;
                    end else begin
                        n_res.status         = rrli_pkg::STAT_APPENDED;
                        w_elem_wr_en         = 1'b1;
                        w_elem_addr          = AW'(r_list) * AW'(LIST_DEPTH) + AW'(w_slot);
                        w_ctrl_wr_en         = 1'b1;
                        w_ctrl_wr_data       = {w_fill + FW'(1), w_head};
                        n_ctrl_vld[r_list]   = 1'b1;
                        n_nonempty[r_list]   = 1'b1;
                    end
                end else if (!r_found) begin
                    n_res.served_list = '0;
                    n_res.status      = rrli_pkg::STAT_EMPTY;
                    n_state           = rrli_pkg::S_SEND;
                end else begin
                    n_res.served_list  = rrli_pkg::IDX_W'(r_list);
                    n_res.status       = rrli_pkg::STAT_TAKEN;
                    w_elem_rd_en       = 1'b1;
                    w_ctrl_wr_en       = 1'b1;
                    w_ctrl_wr_data     = {w_fill - FW'(1), w_head_next};
                    n_nonempty[r_list] = (w_fill != FW'(1));
                    n_rr               = (r_list == LW'(NUM_LISTS - 1)) ? '0
                                                                        : r_list + LW'(1);
                    n_state            = rrli_pkg::S_DATA;
                end
            end
            rrli_pkg::S_DATA: begin
                n_res.out_value = rrli_pkg::DATA_W'(w_elem_s);
                n_state         = rrli_pkg::S_SEND;
            end
            rrli_pkg::S_SEND: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_item  = r_res;
                    n_state     = rrli_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrli_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrli_pkg::S_IDLE;
            r_rr        <= '0;
            r_nonempty  <= '0;
            r_ctrl_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rr        <= n_rr;
            r_nonempty  <= n_nonempty;
            r_ctrl_vld  <= n_ctrl_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_idx_ok   <= n_idx_ok;
        r_found    <= n_found;
        r_vldq     <= n_vldq;
        r_list     <= n_list;
        r_idx_in   <= n_idx_in;
        r_value    <= n_value;
        r_res      <= n_res;
        r_out_item <= n_out_item;
    end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// testbench of the round-robin list interleaver: directed table, then checked random batches
`default_nettype none

module tb;

    localparam int NUM_LISTS  = rrli_pkg::NUM_LISTS_DEF;
    localparam int LIST_DEPTH = rrli_pkg::LIST_DEPTH_DEF;

    typedef struct packed {
        logic                have_want;
        rrli_pkg::t_out_item want;
        rrli_pkg::t_in_item  item;
    } t_stim_row;

    localparam int N_DIRECTED = 22;
    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{1'b1, '{32'h00000000, 3'd0, rrli_pkg::STAT_EMPTY},
          '{rrli_pkg::FUNC_TAKE,   3'd0, 32'h00000000}},
        '{1'b1, '{32'h00000000, 3'd0, rrli_pkg::STAT_APPENDED},
          '{rrli_pkg::FUNC_APPEND, 3'd0, 32'h7fffffff}},
        '{1'b1, '{32'h00000000, 3'd7, rrli_pkg::STAT_APPENDED},
          '{rrli_pkg::FUNC_APPEND, 3'd7, 32'h80000000}},
        '{1'b1, '{32'h00000000, 3'd3, rrli_pkg::STAT_APPENDED},
          '{rrli_pkg::FUNC_APPEND, 3'd3, 32'hffffffff}},
        '{1'b1, '{32'h00000000, 3'd5, rrli_pkg::STAT_APPENDED},
          '{rrli_pkg::FUNC_APPEND, 3'd5, 32'h00000000}},
        '{1'b0, '0,
          '{rrli_pkg::FUNC_APPEND, 3'd0, 32'h12345678}},
        '{1'b1, '{32'h7fffffff, 3'd0, rrli_pkg::STAT_TAKEN},
          '{rrli_pkg::FUNC_TAKE,   3'd7, 32'hffffffff}},
        '{1'b1, '{32'hffffffff, 3'd3, rrli_pkg::STAT_TAKEN},
          '{rrli_pkg::FUNC_TAKE,   3'd0, 32'h00000000}},
        '{1'b0, '0,
          '{rrli_pkg::FUNC_TAKE,   3'd2, 32'h0000ffff}},
        '{1'b1, '{32'h80000000, 3'd7, rrli_pkg::STAT_TAKEN},
          '{rrli_pkg::FUNC_TAKE,   3'd0, 32'h00000000}},
        '{1'b0, '0,
          '{rrli_pkg::FUNC_TAKE,   3'd4, 32'hffff0000}},
        '{1'b1, '{32'h00000000, 3'd0, rrli_pkg::STAT_EMPTY},
          '{rrli_pkg::FUNC_TAKE,   3'd0, 32'h00000000}},
        '{1'b0, '0,
          '{rrli_pkg::FUNC_APPEND, 3'd1, 32'h55555555}},
        '{1'b0, '0,
          '{rrli_pkg::FUNC_APPEND, 3'd6, 32'haaaaaaaa}},
        '{1'b0, '0,
          '{rrli_pkg::FUNC_APPEND, 3'd2, 32'h00000001}},
        '{1'b0, '0,
          '{rrli_pkg::FUNC_APPEND, 3'd1, 32'hfffffffe}},
        '{1'b0, '0,
          '{rrli_pkg::FUNC_TAKE,   3'd0, 32'h00000000}},
        '{1'b0, '0,
          '{rrli_pkg::FUNC_TAKE,   3'd0, 32'h00000000}},
        '{1'b0, '0,
          '{rrli_pkg::FUNC_TAKE,   3'd0, 32'h00000000}},
        '{1'b0, '0,
          '{rrli_pkg::FUNC_TAKE,   3'd0, 32'h00000000}},
        '{1'b1, '{32'h00000000, 3'd0, rrli_pkg::STAT_EMPTY},
          '{rrli_pkg::FUNC_TAKE,   3'd0, 32'h00000000}},
        '{1'b1, '{32'h00000000, 3'd0, rrli_pkg::STAT_EMPTY},
          '{rrli_pkg::FUNC_TAKE,   3'd5, 32'h80000000}}
    };

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    rrli_pkg::t_in_item  i_in_item   = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    rrli_pkg::t_out_item o_out_item;

    // predictor state
    logic [rrli_pkg::DATA_W-1:0] list_mem [NUM_LISTS][LIST_DEPTH];
    int                read_pos [NUM_LISTS];
    int                fill_cnt [NUM_LISTS];
    int                rr_next;
    int                n_appended, n_dropped, n_taken, n_empty;

    t_stim_row           pending_rows [$];
    rrli_pkg::t_out_item expected_results [$];
    rrli_pkg::t_out_item predicted;
    int                  mismatch_count;
    int                  send_idle_pct, out_stall_pct;
    int                  hold_left;

    round_robin_list_interleaver i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic rrli_pkg::t_out_item predict_result(rrli_pkg::t_in_item it);
        rrli_pkg::t_out_item r;
        int                  lst;
        r = '0;
        if (it.func == rrli_pkg::FUNC_APPEND) begin
            r.served_list = it.list_index;
            if (fill_cnt[it.list_index] >= LIST_DEPTH) begin
                r.status = rrli_pkg::STAT_DROPPED;
                n_dropped++;
            end else begin
                list_mem[it.list_index][(read_pos[it.list_index] + fill_cnt[it.list_index])
                                        % LIST_DEPTH] = it.value;
                fill_cnt[it.list_index]++;
                r.status = rrli_pkg::STAT_APPENDED;
                n_appended++;
            end
        end else begin
            r.status = rrli_pkg::STAT_EMPTY;
            for (int k = 0; k < NUM_LISTS; k++) begin
                lst = (rr_next + k) % NUM_LISTS;
                if (r.status == rrli_pkg::STAT_EMPTY && fill_cnt[lst] != 0) begin
                    r.out_value   = list_mem[lst][read_pos[lst]];
                    r.served_list = lst[rrli_pkg::IDX_W-1:0];
                    r.status      = rrli_pkg::STAT_TAKEN;
                    read_pos[lst] = (read_pos[lst] + 1) % LIST_DEPTH;
                    fill_cnt[lst]--;
                    rr_next = (lst + 1) % NUM_LISTS;
                end
            end
            if (r.status == rrli_pkg::STAT_EMPTY) n_empty++;
            else n_taken++;
        end
        return r;
    endfunction

    task automatic check_result(rrli_pkg::t_out_item got);
        rrli_pkg::t_out_item want;
        if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result: value %h list %0d status %0d",
                         got.out_value, got.served_list, got.status);
        end else begin
            want = expected_results[0];
            expected_results.delete(0);
            if (got.out_value !== want.out_value || got.served_list !== want.served_list ||
                got.status !== want.status) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                             want.out_value, want.served_list, want.status,
                             got.out_value, got.served_list, got.status);
            end
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted = predict_result(i_in_item);
                expected_results.insert(expected_results.size(),
                                        pending_rows[0].have_want ? pending_rows[0].want
                                                                  : predicted);
                pending_rows.delete(0);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_rows.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= pending_rows[0].item;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) check_result(o_out_item);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < out_stall_pct);
            end
        end
    end

    function automatic logic [rrli_pkg::DATA_W-1:0] pick_value();
        unique case ($urandom_range(7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic void add_row(logic f, int lst);
        t_stim_row row;
        row.have_want       = 1'b0;
        row.want            = '0;
        row.item.func       = f;
        row.item.list_index = lst[rrli_pkg::IDX_W-1:0];
        row.item.value      = pick_value();
        pending_rows.insert(pending_rows.size(), row);
    endfunction

    function automatic int mixed_batch(int n);
        for (int j = 0; j < n; j++)
            add_row(($urandom_range(99) < 55) ? rrli_pkg::FUNC_APPEND : rrli_pkg::FUNC_TAKE,
                    $urandom_range(7));
        return n;
    endfunction

    // append to a subset of lists, then take as many times plus up to three more
    function automatic int load_drain_batch();
        logic [NUM_LISTS-1:0] mask;
        int                   k, n_take, lst;
        mask   = NUM_LISTS'($urandom_range(1, 255));
        k      = $urandom_range(4, 24);
        n_take = k + $urandom_range(0, 3);
        for (int j = 0; j < k; j++) begin
            do lst = $urandom_range(NUM_LISTS - 1); while (!mask[lst]);
            add_row(rrli_pkg::FUNC_APPEND, lst);
        end
        for (int j = 0; j < n_take; j++) add_row(rrli_pkg::FUNC_TAKE, $urandom_range(7));
        return k + n_take;
    endfunction

    // fill one list past full so the tail appends are dropped
    function automatic int fill_batch(int lst);
        int n_app, n_take;
        n_app  = LIST_DEPTH - fill_cnt[lst] + $urandom_range(1, 4);
        n_take = $urandom_range(0, 8);
        for (int j = 0; j < n_app; j++) add_row(rrli_pkg::FUNC_APPEND, lst);
        for (int j = 0; j < n_take; j++) add_row(rrli_pkg::FUNC_TAKE, $urandom_range(7));
        return n_app + n_take;
    endfunction

    task automatic wait_drained();
        while (pending_rows.size() != 0 || expected_results.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int phase_items;
        for (int l = 0; l < NUM_LISTS; l++) begin
            read_pos[l] = 0;
            fill_cnt[l] = 0;
        end
        rr_next        = 0;
        n_appended     = 0;
        n_dropped      = 0;
        n_taken        = 0;
        n_empty        = 0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        out_stall_pct  = 0;
        hold_left      = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (DIRECTED_ROWS[i]) pending_rows.insert(pending_rows.size(), DIRECTED_ROWS[i]);
        wait_drained();
        for (int phase = 0; phase < 4; phase++) begin
            unique case (phase)
                0: begin send_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin send_idle_pct = 84; out_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  out_stall_pct = 84; end
                default: begin send_idle_pct = 12; out_stall_pct = 12; end
            endcase
            phase_items = 0;
            if (phase == 0) begin
                hold_left = 300;
                phase_items += mixed_batch(40);
                wait_drained();
            end
            if (phase == 0 || phase == 3) begin
                phase_items += fill_batch($urandom_range(NUM_LISTS - 1));
                wait_drained();
            end
            while (phase_items < 410) begin
                if ($urandom_range(9) < 6) phase_items += load_drain_batch();
                else phase_items += mixed_batch($urandom_range(5, 40));
                wait_drained();
            end
        end
        repeat (20) @(posedge i_clk);
        $display("covered %0d appends, %0d drops on a full list, %0d takes, %0d empty takes",
                 n_appended, n_dropped, n_taken, n_empty);
        $display("under no idling, sender gaps, receiver stalls, both, and a long output hold");
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/rrli_pkg.sv
rtl/rrli_ram.sv
rtl/rrli_pick.sv
rtl/round_robin_list_interleaver.sv
tb/sv/tb.sv
